// ===== hdl/segint_pkg.sv =====
package segint_pkg;

  localparam int COORD_W = 20;               // input and output coordinate width
  localparam int DELTA_W = COORD_W + 1;      // endpoint difference
  localparam int MAG_W   = COORD_W;          // magnitude of an endpoint difference
  localparam int PROD_W  = 2 * DELTA_W;      // one cross-product term
  localparam int CROSS_W = PROD_W + 1;       // difference of two terms
  localparam int QUO_W   = COORD_W + 1;      // quotient bits, t*|d| <= |d|
  localparam int NUM_W   = 64;               // dividend width, tn * |d|

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DELTA_W-1:0] delta_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [CROSS_W-1:0] cross_t;

  // Sideband that rides along with one divider lane.
  typedef struct packed {
    logic   hit;
    logic   neg;
    coord_t start;
  } tag_t;

  function automatic prod_t mul_s(input delta_t a, input delta_t b);
    prod_t ea;
    prod_t eb;
    ea = a;
    eb = b;
    return ea * eb;
  endfunction

  function automatic cross_t sub_x(input prod_t a, input prod_t b);
    cross_t ea;
    cross_t eb;
    ea = a;
    eb = b;
    return ea - eb;
  endfunction

endpackage

// ===== hdl/segment_intersection_unit.sv =====
// Channel   Ports                                  Handshake
// input     in_a_*/in_b_* start/end x,y (Q16.4)    start && !busy
// result    out_hit, out_cross_x, out_cross_y      out_valid, one cycle
//
// One segment pair enters per cycle; busy is always low.
// Stages: input register, products, cross terms, sign
// normalize and hit test, dividend product, 21 restoring divider stages
// (one quotient bit each), output register.
// rst_n clears only the valid bits; no data is cleared.
// The receiver cannot stall, so the pipeline never holds.
module segment_intersection_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  segint_pkg::coord_t        in_a_start_x,
  input  segint_pkg::coord_t        in_a_start_y,
  input  segint_pkg::coord_t        in_a_end_x,
  input  segint_pkg::coord_t        in_a_end_y,
  input  segint_pkg::coord_t        in_b_start_x,
  input  segint_pkg::coord_t        in_b_start_y,
  input  segint_pkg::coord_t        in_b_end_x,
  input  segint_pkg::coord_t        in_b_end_y,
  output logic                      out_valid,
  output logic                      out_hit,
  output segint_pkg::coord_t        out_cross_x,
  output segint_pkg::coord_t        out_cross_y
);
  import segint_pkg::*;

  assign busy = 1'b0;

  // Stage 0: take the word and form the differences.
  logic   s0_vld_r;
  coord_t s0_ax_r, s0_ay_r;
  delta_t s0_d1x_r, s0_d1y_r, s0_d2x_r, s0_d2y_r, s0_wx_r, s0_wy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else begin
      s0_vld_r <= start && !busy;
    end
    s0_ax_r  <= in_a_start_x;
    s0_ay_r  <= in_a_start_y;
    s0_d1x_r <= DELTA_W'(in_a_end_x) - DELTA_W'(in_a_start_x);
    s0_d1y_r <= DELTA_W'(in_a_end_y) - DELTA_W'(in_a_start_y);
    s0_d2x_r <= DELTA_W'(in_b_end_x) - DELTA_W'(in_b_start_x);
    s0_d2y_r <= DELTA_W'(in_b_end_y) - DELTA_W'(in_b_start_y);
    s0_wx_r  <= DELTA_W'(in_a_start_x) - DELTA_W'(in_b_start_x);
    s0_wy_r  <= DELTA_W'(in_a_start_y) - DELTA_W'(in_b_start_y);
  end

  // Stage 1: the six cross-product terms.
  logic   s1_vld_r;
  coord_t s1_ax_r, s1_ay_r;
  delta_t s1_d1x_r, s1_d1y_r;
  prod_t  s1_p0_r, s1_p1_r, s1_p2_r, s1_p3_r, s1_p4_r, s1_p5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s0_vld_r;
    end
    s1_ax_r  <= s0_ax_r;
    s1_ay_r  <= s0_ay_r;
    s1_d1x_r <= s0_d1x_r;
    s1_d1y_r <= s0_d1y_r;
    s1_p0_r  <= mul_s(s0_d1x_r, s0_d2y_r);
    s1_p1_r  <= mul_s(s0_d1y_r, s0_d2x_r);
    s1_p2_r  <= mul_s(s0_d1x_r, s0_wy_r);
    s1_p3_r  <= mul_s(s0_d1y_r, s0_wx_r);
    s1_p4_r  <= mul_s(s0_d2x_r, s0_wy_r);
    s1_p5_r  <= mul_s(s0_d2y_r, s0_wx_r);
  end

  // Stage 2: den, sn, tn.
  logic   s2_vld_r;
  coord_t s2_ax_r, s2_ay_r;
  delta_t s2_d1x_r, s2_d1y_r;
  cross_t s2_den_r, s2_sn_r, s2_tn_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
    s2_ax_r  <= s1_ax_r;
    s2_ay_r  <= s1_ay_r;
    s2_d1x_r <= s1_d1x_r;
    s2_d1y_r <= s1_d1y_r;
    s2_den_r <= sub_x(s1_p0_r, s1_p1_r);
    s2_sn_r  <= sub_x(s1_p2_r, s1_p3_r);
    s2_tn_r  <= sub_x(s1_p4_r, s1_p5_r);
  end

  // Stage 3: flip signs so den is non-negative, then test s and t in [0,1].
  cross_t s3_den_nxt, s3_sn_nxt, s3_tn_nxt;
  logic   s3_hit_nxt;

  always_comb begin
    s3_den_nxt = s2_den_r[CROSS_W-1] ? -s2_den_r : s2_den_r;
    s3_sn_nxt  = s2_den_r[CROSS_W-1] ? -s2_sn_r  : s2_sn_r;
    s3_tn_nxt  = s2_den_r[CROSS_W-1] ? -s2_tn_r  : s2_tn_r;
    s3_hit_nxt = (s2_den_r != '0) &&
                 !s3_sn_nxt[CROSS_W-1] && (s3_sn_nxt <= s3_den_nxt) &&
                 !s3_tn_nxt[CROSS_W-1] && (s3_tn_nxt <= s3_den_nxt);
  end

  logic             s3_vld_r, s3_hit_r;
  coord_t           s3_ax_r, s3_ay_r;
  logic             s3_negx_r, s3_negy_r;
  logic [MAG_W-1:0] s3_magx_r, s3_magy_r;
  cross_t           s3_den_r, s3_tn_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
    s3_hit_r  <= s3_hit_nxt;
    s3_ax_r   <= s2_ax_r;
    s3_ay_r   <= s2_ay_r;
    s3_negx_r <= s2_d1x_r[DELTA_W-1];
    s3_negy_r <= s2_d1y_r[DELTA_W-1];
    s3_magx_r <= MAG_W'(s2_d1x_r[DELTA_W-1] ? -s2_d1x_r : s2_d1x_r);
    s3_magy_r <= MAG_W'(s2_d1y_r[DELTA_W-1] ? -s2_d1y_r : s2_d1y_r);
    s3_den_r  <= s3_den_nxt;
    s3_tn_r   <= s3_tn_nxt;
  end

  // Stage 4: dividend tn*|d1| for each axis. On a miss tn may be junk;
  // the result is forced to zero at the end.
  logic               s4_vld_r;
  logic [NUM_W-1:0]   s4_numx_r, s4_numy_r;
  logic [CROSS_W-1:0] s4_den_r;
  tag_t               s4_tagx_r, s4_tagy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else begin
      s4_vld_r <= s3_vld_r;
    end
    s4_numx_r <= NUM_W'(s3_tn_r[CROSS_W-2:0]) * NUM_W'(s3_magx_r);
    s4_numy_r <= NUM_W'(s3_tn_r[CROSS_W-2:0]) * NUM_W'(s3_magy_r);
    s4_den_r  <= s3_den_r;
    s4_tagx_r <= '{hit: s3_hit_r, neg: s3_negx_r, start: s3_ax_r};
    s4_tagy_r <= '{hit: s3_hit_r, neg: s3_negy_r, start: s3_ay_r};
  end

  // Divider lanes, one per axis, in lockstep.
  logic             dx_vld, dy_vld;
  logic [QUO_W-1:0] dx_quo, dy_quo;
  tag_t             dx_tag, dy_tag;

  segint_div u_div_x (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (s4_vld_r),
    .in_num  (s4_numx_r),
    .in_den  (s4_den_r),
    .in_tag  (s4_tagx_r),
    .out_vld (dx_vld),
    .out_quo (dx_quo),
    .out_tag (dx_tag)
  );

  segint_div u_div_y (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (s4_vld_r),
    .in_num  (s4_numy_r),
    .in_den  (s4_den_r),
    .in_tag  (s4_tagy_r),
    .out_vld (dy_vld),
    .out_quo (dy_quo),
    .out_tag (dy_tag)
  );

  // Output: advance the start point by the truncated quotient, drop to
  // zero on a miss.
  coord_t px_nxt, py_nxt;

  always_comb begin
    px_nxt = dx_tag.neg ? dx_tag.start - coord_t'(dx_quo[COORD_W-1:0])
                        : dx_tag.start + coord_t'(dx_quo[COORD_W-1:0]);
    py_nxt = dy_tag.neg ? dy_tag.start - coord_t'(dy_quo[COORD_W-1:0])
                        : dy_tag.start + coord_t'(dy_quo[COORD_W-1:0]);
  end

  logic   out_valid_r, out_hit_r;
  coord_t out_cross_x_r, out_cross_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dx_vld;
    end
    out_hit_r     <= dx_tag.hit;
    out_cross_x_r <= dx_tag.hit ? px_nxt : '0;
    out_cross_y_r <= dx_tag.hit ? py_nxt : '0;
  end

  assign out_valid   = out_valid_r;
  assign out_hit     = out_hit_r;
  assign out_cross_x = out_cross_x_r;
  assign out_cross_y = out_cross_y_r;

  // Both divider lanes must stay in step.
  a_lanes_sync: assert property (@(posedge clk) disable iff (!rst_n)
    dx_vld == dy_vld && (!dx_vld || dx_tag.hit == dy_tag.hit))
    else $error("divider lanes out of step");

  // A hit never comes from a zero denominator.
  a_hit_den: assert property (@(posedge clk) disable iff (!rst_n)
    s3_vld_r && s3_hit_r |-> s3_den_r != '0 && !s3_den_r[CROSS_W-1])
    else $error("hit with non-positive denominator");

  // A miss reports the origin.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_cross_x == '0 && out_cross_y == '0)
    else $error("miss with nonzero point");

endmodule

// ===== hdl/segint_div.sv =====
module segint_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_vld,
  input  logic [segint_pkg::NUM_W-1:0]    in_num,
  input  logic [segint_pkg::CROSS_W-1:0]  in_den,
  input  segint_pkg::tag_t                in_tag,
  output logic                            out_vld,
  output logic [segint_pkg::QUO_W-1:0]    out_quo,
  output segint_pkg::tag_t                out_tag
);
  import segint_pkg::*;

  // One quotient bit per stage, most significant first.
  logic               vld_r [1:QUO_W];
  logic [NUM_W-1:0]   rem_r [1:QUO_W];
  logic [CROSS_W-1:0] den_r [1:QUO_W];
  logic [QUO_W-1:0]   quo_r [1:QUO_W];
  tag_t               tag_r [1:QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic               v_in;
    logic [NUM_W-1:0]   r_in;
    logic [CROSS_W-1:0] d_in;
    logic [QUO_W-1:0]   q_in;
    tag_t               t_in;
    logic [NUM_W-1:0]   dsh;
    logic [NUM_W:0]     diff;
    logic [QUO_W-1:0]   q_nxt;
    logic [NUM_W-1:0]   rem_nxt;

    if (k == 0) begin : g_first
      assign v_in = in_vld;
      assign r_in = in_num;
      assign d_in = in_den;
      assign q_in = '0;
      assign t_in = in_tag;
    end else begin : g_next
      assign v_in = vld_r[k];
      assign r_in = rem_r[k];
      assign d_in = den_r[k];
      assign q_in = quo_r[k];
      assign t_in = tag_r[k];
    end

    always_comb begin
      dsh     = NUM_W'(d_in) << (QUO_W - 1 - k);
      diff    = {1'b0, r_in} - {1'b0, dsh};
      q_nxt   = q_in;
      q_nxt[QUO_W-1-k] = !diff[NUM_W];
      rem_nxt = diff[NUM_W] ? r_in : diff[NUM_W-1:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else begin
        vld_r[k+1] <= v_in;
      end
      rem_r[k+1] <= rem_nxt;
      den_r[k+1] <= d_in;
      quo_r[k+1] <= q_nxt;
      tag_r[k+1] <= t_in;
    end
  end

  assign out_vld = vld_r[QUO_W];
  assign out_quo = quo_r[QUO_W];
  assign out_tag = tag_r[QUO_W];

endmodule
